### rtl/core/pic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants of the convex polygon point test
// Coordinate, sign and handshake types used by the sequencer, the shared
// cross-product unit and the top level.
// ----------------------------------------------------------------------------
package pic_pkg;

    localparam int COORD_W = 31;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // Request codes on the input channel
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // Sign of a cross product; both bits low means zero
    typedef struct packed {
        logic neg;
        logic pos;
    } sign_t;

    typedef struct packed {
        logic   start;
        point_t p;
        point_t o;
        point_t q;
    } cx_req_t;

    typedef struct packed {
        logic  done;
        sign_t sign;
    } cx_rsp_t;

    typedef enum logic [1:0] {
        CX_IDLE,
        CX_MUL_A,
        CX_MUL_B,
        CX_CMP
    } cx_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_V0,
        ST_V1,
        ST_W1,
        ST_WN,
        ST_SEARCH_RD,
        ST_SEARCH_CX,
        ST_SEARCH_W,
        ST_TRI_RL,
        ST_TRI_RR,
        ST_TRI_C1,
        ST_TRI_W1,
        ST_TRI_W2,
        ST_TRI_W3,
        ST_TRI_W4,
        ST_FINISH
    } seq_state_t;

    // Angle test: passes unless both signs are strictly equal and nonzero
    function automatic logic wedge_pass(input sign_t a, input sign_t b);
        wedge_pass = !((a.pos && b.pos) || (a.neg && b.neg));
    endfunction

endpackage
`default_nettype wire

### rtl/core/pic_cross.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_cross: shared cross-product sign unit
// Computes sign((p - o) x (q - o)) with one 32x32 multiplier used twice,
// then a 64-bit compare; done rises with the registered sign.
// ----------------------------------------------------------------------------
module pic_cross (
    input  wire               aclk,
    input  wire               aresetn,
    input  pic_pkg::cx_req_t  req,
    output pic_pkg::cx_rsp_t  rsp
);

    pic_pkg::cx_phase_t phase_reg, phase_next;

    logic signed [pic_pkg::DIFF_W-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [pic_pkg::PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic signed [pic_pkg::DIFF_W-1:0] mul_l, mul_r;
    logic signed [pic_pkg::PROD_W-1:0] mul_out;
    logic        done_reg;
    pic_pkg::sign_t sign_reg;

    // Advance through the two products and the compare
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            pic_pkg::CX_IDLE:  if (req.start) phase_next = pic_pkg::CX_MUL_A;
            pic_pkg::CX_MUL_A: phase_next = pic_pkg::CX_MUL_B;
            pic_pkg::CX_MUL_B: phase_next = pic_pkg::CX_CMP;
            pic_pkg::CX_CMP:   phase_next = pic_pkg::CX_IDLE;
            default:           phase_next = pic_pkg::CX_IDLE;
        endcase
    end

    always_comb begin
        if (phase_reg == pic_pkg::CX_MUL_A) begin
            mul_l = ux_reg;
            mul_r = vy_reg;
        end else begin
            mul_l = uy_reg;
            mul_r = vx_reg;
        end
        mul_out = mul_l * mul_r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pic_pkg::CX_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == pic_pkg::CX_CMP);
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == pic_pkg::CX_IDLE && req.start) begin
            ux_reg <= $signed({req.p.x[pic_pkg::COORD_W-1], req.p.x})
                    - $signed({req.o.x[pic_pkg::COORD_W-1], req.o.x});
            uy_reg <= $signed({req.p.y[pic_pkg::COORD_W-1], req.p.y})
                    - $signed({req.o.y[pic_pkg::COORD_W-1], req.o.y});
            vx_reg <= $signed({req.q.x[pic_pkg::COORD_W-1], req.q.x})
                    - $signed({req.o.x[pic_pkg::COORD_W-1], req.o.x});
            vy_reg <= $signed({req.q.y[pic_pkg::COORD_W-1], req.q.y})
                    - $signed({req.o.y[pic_pkg::COORD_W-1], req.o.y});
        end
        if (phase_reg == pic_pkg::CX_MUL_A) begin
            prod_a_reg <= mul_out;
        end
        if (phase_reg == pic_pkg::CX_MUL_B) begin
            prod_b_reg <= mul_out;
        end
        if (phase_reg == pic_pkg::CX_CMP) begin
            sign_reg.pos <= (prod_a_reg > prod_b_reg);
            sign_reg.neg <= (prod_a_reg < prod_b_reg);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sign = sign_reg;

endmodule
`default_nettype wire

### rtl/core/pic_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_seq: query sequencer
// Walks the wedge test at vertex 0, the binary search over the fan and the
// final triangle test, issuing vertex reads and cross-product jobs.
// ----------------------------------------------------------------------------
module pic_seq #(
    parameter int ADDR_W = 10,
    parameter int CNT_W  = 11
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   start,
    input  pic_pkg::point_t       start_p,
    input  wire  [CNT_W-1:0]      start_n,
    output logic                  busy,
    output logic                  rd_en,
    output logic [ADDR_W-1:0]     rd_addr,
    input  pic_pkg::point_t       rd_data,
    output pic_pkg::cx_req_t      cx_req,
    input  pic_pkg::cx_rsp_t      cx_rsp,
    output logic                  res_valid,
    output logic                  res_inside,
    output logic                  res_poly_valid,
    input  wire                   out_free
);

    pic_pkg::seq_state_t state_reg, state_next;

    pic_pkg::point_t  p_reg, v0_reg, vl_reg, vr_reg;
    logic [ADDR_W-1:0] l_reg, r_reg, m_reg, last_idx;
    pic_pkg::sign_t   sign_l_reg, sign_r_reg, s1_reg;
    logic             tri_ok_reg, inside_reg, pv_reg;
    logic             too_few;
    logic [ADDR_W:0]  lr_sum;
    logic [ADDR_W-1:0] mid, l_new, r_new;
    logic             step_pass, first_pass, gap_now, gap_new;

    always_comb begin
        too_few    = (start_n < CNT_W'(3));
        last_idx   = ADDR_W'(start_n - CNT_W'(1));
        lr_sum     = {1'b0, l_reg} + {1'b0, r_reg};
        mid        = lr_sum[ADDR_W:1];
        step_pass  = pic_pkg::wedge_pass(sign_l_reg, cx_rsp.sign);
        first_pass = pic_pkg::wedge_pass(sign_l_reg, cx_rsp.sign);
        l_new      = step_pass ? l_reg : m_reg;
        r_new      = step_pass ? m_reg : r_reg;
        gap_now    = (r_reg - l_reg) > ADDR_W'(1);
        gap_new    = (r_new - l_new) > ADDR_W'(1);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pic_pkg::ST_IDLE: begin
                if (start) state_next = too_few ? pic_pkg::ST_FINISH : pic_pkg::ST_V0;
            end
            pic_pkg::ST_V0:        state_next = pic_pkg::ST_V1;
            pic_pkg::ST_V1:        state_next = pic_pkg::ST_W1;
            pic_pkg::ST_W1:        if (cx_rsp.done) state_next = pic_pkg::ST_WN;
            pic_pkg::ST_WN: begin
                if (cx_rsp.done) begin
                    if (!first_pass) state_next = pic_pkg::ST_FINISH;
                    else if (gap_now) state_next = pic_pkg::ST_SEARCH_RD;
                    else state_next = pic_pkg::ST_TRI_RL;
                end
            end
            pic_pkg::ST_SEARCH_RD: state_next = pic_pkg::ST_SEARCH_CX;
            pic_pkg::ST_SEARCH_CX: state_next = pic_pkg::ST_SEARCH_W;
            pic_pkg::ST_SEARCH_W: begin
                if (cx_rsp.done) begin
                    state_next = gap_new ? pic_pkg::ST_SEARCH_RD : pic_pkg::ST_TRI_RL;
                end
            end
            pic_pkg::ST_TRI_RL:    state_next = pic_pkg::ST_TRI_RR;
            pic_pkg::ST_TRI_RR:    state_next = pic_pkg::ST_TRI_C1;
            pic_pkg::ST_TRI_C1:    state_next = pic_pkg::ST_TRI_W1;
            pic_pkg::ST_TRI_W1:    if (cx_rsp.done) state_next = pic_pkg::ST_TRI_W2;
            pic_pkg::ST_TRI_W2:    if (cx_rsp.done) state_next = pic_pkg::ST_TRI_W3;
            pic_pkg::ST_TRI_W3:    if (cx_rsp.done) state_next = pic_pkg::ST_TRI_W4;
            pic_pkg::ST_TRI_W4:    if (cx_rsp.done) state_next = pic_pkg::ST_FINISH;
            pic_pkg::ST_FINISH:    if (out_free) state_next = pic_pkg::ST_IDLE;
            default:               state_next = pic_pkg::ST_IDLE;
        endcase
    end

    // Outputs: read port, cross-product jobs, result
    always_comb begin
        busy      = (state_reg != pic_pkg::ST_IDLE);
        rd_en     = 1'b0;
        rd_addr   = '0;
        cx_req.start = 1'b0;
        cx_req.p  = p_reg;
        cx_req.o  = v0_reg;
        cx_req.q  = rd_data;
        res_valid = (state_reg == pic_pkg::ST_FINISH);
        res_inside     = inside_reg;
        res_poly_valid = pv_reg;
        case (state_reg)
            pic_pkg::ST_IDLE: begin
                rd_en = start;
            end
            pic_pkg::ST_V0: begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(1);
            end
            pic_pkg::ST_V1: begin
                rd_en   = 1'b1;
                rd_addr = r_reg;
                cx_req.start = 1'b1;
            end
            pic_pkg::ST_W1: begin
                cx_req.start = cx_rsp.done;
            end
            pic_pkg::ST_SEARCH_RD: begin
                rd_en   = 1'b1;
                rd_addr = mid;
            end
            pic_pkg::ST_SEARCH_CX: begin
                cx_req.start = 1'b1;
            end
            pic_pkg::ST_TRI_RL: begin
                rd_en   = 1'b1;
                rd_addr = l_reg;
            end
            pic_pkg::ST_TRI_RR: begin
                rd_en   = 1'b1;
                rd_addr = r_reg;
            end
            pic_pkg::ST_TRI_C1: begin
                cx_req.start = 1'b1;
                cx_req.o     = vl_reg;
            end
            pic_pkg::ST_TRI_W1: begin
                cx_req.start = cx_rsp.done;
                cx_req.o     = vl_reg;
                cx_req.q     = v0_reg;
            end
            pic_pkg::ST_TRI_W2: begin
                cx_req.start = cx_rsp.done;
                cx_req.o     = vr_reg;
                cx_req.q     = v0_reg;
            end
            pic_pkg::ST_TRI_W3: begin
                cx_req.start = cx_rsp.done;
                cx_req.o     = vr_reg;
                cx_req.q     = vl_reg;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // In ST_V1 the origin is v0 itself; v0_reg already holds it there
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pic_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            pic_pkg::ST_IDLE: begin
                if (start) begin
                    p_reg      <= start_p;
                    l_reg      <= ADDR_W'(1);
                    r_reg      <= last_idx;
                    inside_reg <= 1'b0;
                    pv_reg     <= !too_few;
                end
            end
            pic_pkg::ST_V0: begin
                v0_reg <= rd_data;
            end
            pic_pkg::ST_W1: begin
                if (cx_rsp.done) sign_l_reg <= cx_rsp.sign;
            end
            pic_pkg::ST_WN: begin
                if (cx_rsp.done) sign_r_reg <= cx_rsp.sign;
            end
            pic_pkg::ST_SEARCH_RD: begin
                m_reg <= mid;
            end
            pic_pkg::ST_SEARCH_W: begin
                if (cx_rsp.done) begin
                    l_reg <= l_new;
                    r_reg <= r_new;
                    if (step_pass) sign_r_reg <= cx_rsp.sign;
                    else sign_l_reg <= cx_rsp.sign;
                end
            end
            pic_pkg::ST_TRI_RR: begin
                vl_reg <= rd_data;
            end
            pic_pkg::ST_TRI_C1: begin
                vr_reg <= rd_data;
            end
            pic_pkg::ST_TRI_W1: begin
                if (cx_rsp.done) s1_reg <= cx_rsp.sign;
            end
            pic_pkg::ST_TRI_W2: begin
                if (cx_rsp.done) begin
                    tri_ok_reg <= pic_pkg::wedge_pass(s1_reg, cx_rsp.sign)
                               && pic_pkg::wedge_pass(sign_l_reg, sign_r_reg);
                end
            end
            pic_pkg::ST_TRI_W3: begin
                if (cx_rsp.done) s1_reg <= cx_rsp.sign;
            end
            pic_pkg::ST_TRI_W4: begin
                if (cx_rsp.done) begin
                    inside_reg <= tri_ok_reg && pic_pkg::wedge_pass(s1_reg, cx_rsp.sign);
                end
            end
            default: begin
                m_reg <= m_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/point_in_convex_polygon.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_convex_polygon: convex polygon point test by fan binary search
// Vertex store, request handshake and result register around the query
// sequencer and the shared cross-product unit.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel (valid/ready). A load request
//   (s_opcode low) stores one vertex in order; s_restart on a load empties
//   the store first. Loads beyond MAX_VERTICES are dropped.
//   A load returns nothing.
//   A query request (s_opcode high) tests the point and returns one result
//   on the m_ channel: m_inside_res (inside or on the boundary) and
//   m_polygon_valid (at least three vertices stored).
//   With fewer than three vertices a query goes straight to its result.
//   Query time is set by the one shared cross-product unit and the
//   single vertex read port, one read per search step. s_ready is low
//   while a query runs.
//   The result sits in an output register; when the receiver stalls,
//   the block holds it and finishes the next query only once it is taken.
//   Loads are still accepted while a result waits.
//   Synchronous reset empties the store (count to zero) and drops any
//   pending result; vertex storage itself is not cleared.
// ----------------------------------------------------------------------------
module point_in_convex_polygon #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire                                  s_opcode,
    input  wire signed [pic_pkg::COORD_W-1:0]    s_x_coord,
    input  wire signed [pic_pkg::COORD_W-1:0]    s_y_coord,
    input  wire                                  s_restart,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic                                 m_inside_res,
    output logic                                 m_polygon_valid
);

    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    // Vertex store: one write port (loads), one registered read port (queries)
    pic_pkg::point_t vtx_mem [MAX_VERTICES];
    pic_pkg::point_t rd_data_reg;

    logic [CNT_W-1:0]  vertex_count_reg, vertex_count_next;
    logic [CNT_W-1:0]  count_base;
    logic              load_fire, query_fire, wr_en;
    logic [ADDR_W-1:0] wr_addr;
    pic_pkg::point_t   in_point;

    logic              seq_busy, rd_en;
    logic [ADDR_W-1:0] rd_addr;
    pic_pkg::cx_req_t  cx_req;
    pic_pkg::cx_rsp_t  cx_rsp;
    logic              res_valid, res_inside, res_poly_valid, out_free;

    logic              m_valid_reg, m_inside_reg, m_pv_reg;

    assign s_ready    = !seq_busy;
    assign load_fire  = s_valid && s_ready && (s_opcode == pic_pkg::OP_LOAD);
    assign query_fire = s_valid && s_ready && (s_opcode == pic_pkg::OP_QUERY);
    assign in_point.x = s_x_coord;
    assign in_point.y = s_y_coord;

    // Restart empties the store ahead of the vertex; a full store drops it
    always_comb begin
        count_base        = s_restart ? '0 : vertex_count_reg;
        wr_en             = load_fire && (count_base < CNT_W'(MAX_VERTICES));
        wr_addr           = count_base[ADDR_W-1:0];
        vertex_count_next = vertex_count_reg;
        if (wr_en) begin
            vertex_count_next = count_base + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
        end else begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            vtx_mem[wr_addr] <= in_point;
        end
        if (rd_en) begin
            rd_data_reg <= vtx_mem[rd_addr];
        end
    end

    pic_seq #(
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (query_fire),
        .start_p        (in_point),
        .start_n        (vertex_count_reg),
        .busy           (seq_busy),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data_reg),
        .cx_req         (cx_req),
        .cx_rsp         (cx_rsp),
        .res_valid      (res_valid),
        .res_inside     (res_inside),
        .res_poly_valid (res_poly_valid),
        .out_free       (out_free)
    );

    pic_cross u_cross (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cx_req),
        .rsp     (cx_rsp)
    );

    // Output register: load a finished result once the previous one is taken
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_inside_reg <= res_inside;
            m_pv_reg     <= res_poly_valid;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_inside_res    = m_inside_reg;
    assign m_polygon_valid = m_pv_reg;

endmodule
`default_nettype wire

### rtl/core/pic_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_checker: port-level checks for point_in_convex_polygon
// Watches the request and result channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module pic_checker (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_valid,
    input wire                               s_ready,
    input wire                               s_opcode,
    input wire                               m_valid,
    input wire                               m_ready,
    input wire                               m_inside_res,
    input wire                               m_polygon_valid
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inside_res)
                                && $stable(m_polygon_valid))
        else $error("result changed while stalled");

    // No polygon means never inside
    a_invalid_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_polygon_valid |-> !m_inside_res)
        else $error("inside reported on invalid polygon");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A query request drops s_ready in the cycle after it is accepted
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode |=> !s_ready)
        else $error("ready right after query request");

    // A load request does not make the block busy
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_opcode |=> s_ready)
        else $error("ready dropped after load request");

endmodule

bind point_in_convex_polygon pic_checker u_pic_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_opcode        (s_opcode),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_inside_res    (m_inside_res),
    .m_polygon_valid (m_polygon_valid)
);
`default_nettype wire

### sim/point_in_convex_polygon_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_convex_polygon_check: request/result checker for the polygon test
// Mirrors the vertex store from accepted load requests, predicts the answer
// of every accepted query and compares it with the results as they leave.
// ----------------------------------------------------------------------------
module point_in_convex_polygon_check #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    input  wire                                s_ready,
    input  wire                                s_opcode,
    input  wire signed [pic_pkg::COORD_W-1:0]  s_x_coord,
    input  wire signed [pic_pkg::COORD_W-1:0]  s_y_coord,
    input  wire                                s_restart,
    input  wire                                m_valid,
    input  wire                                m_ready,
    input  wire                                m_inside_res,
    input  wire                                m_polygon_valid,
    output int                                 mismatches,
    output int                                 pending
);

    typedef struct packed {
        logic in_poly;
        logic valid;
    } answer_t;

    logic signed [pic_pkg::COORD_W-1:0] vert_x [MAX_VERTICES];
    logic signed [pic_pkg::COORD_W-1:0] vert_y [MAX_VERTICES];
    int unsigned                        vert_count = 0;
    answer_t                            answer_q [$];
    answer_t                            oldest;

    initial mismatches = 0;
    initial pending = 0;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Sign of (p - o) x (q - o), exact at 66 bits
    function automatic int cross_sign(input logic signed [pic_pkg::COORD_W-1:0] px, py,
                                      input logic signed [pic_pkg::COORD_W-1:0] ox, oy,
                                      input logic signed [pic_pkg::COORD_W-1:0] qx, qy);
        logic signed [pic_pkg::PROD_W+1:0] ux, uy, wx, wy, c;
        ux = px - ox;
        uy = py - oy;
        wx = qx - ox;
        wy = qy - oy;
        c  = ux * wy - uy * wx;
        return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
    endfunction

    // Point lies in the closed angle at vertex o between vertices a and b
    function automatic logic in_angle(input logic signed [pic_pkg::COORD_W-1:0] px, py,
                                      input int o, input int a, input int b);
        int sa, sb;
        sa = cross_sign(px, py, vert_x[o], vert_y[o], vert_x[a], vert_y[a]);
        sb = cross_sign(px, py, vert_x[o], vert_y[o], vert_x[b], vert_y[b]);
        return (sa * sb) <= 0;
    endfunction

    function automatic answer_t predict_answer(
        input logic signed [pic_pkg::COORD_W-1:0] px, py);
        answer_t ans;
        int      n, lo, hi, mid;
        ans = '0;
        n   = vert_count;
        if (n < 3)
            return ans;
        ans.valid = 1'b1;
        lo = 1;
        hi = n - 1;
        if (in_angle(px, py, 0, 1, n - 1)) begin
            // narrow the fan down to one triangle (v0, v[lo], v[hi])
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (in_angle(px, py, 0, lo, mid))
                    hi = mid;
                else
                    lo = mid;
            end
            ans.in_poly = in_angle(px, py, 0, lo, hi) && in_angle(px, py, lo, hi, 0) &&
                          in_angle(px, py, hi, 0, lo);
        end
        return ans;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            vert_count = 0;
            answer_q.delete();
        end else begin
            // compare a leaving result before taking a new request in
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch($sformatf("result inside=%b valid=%b with no query open",
                                              m_inside_res, m_polygon_valid));
                end else begin
                    oldest = answer_q.pop_front();
                    if (m_inside_res !== oldest.in_poly)
                        report_mismatch($sformatf("inside_res got %b, want %b",
                                                  m_inside_res, oldest.in_poly));
                    if (m_polygon_valid !== oldest.valid)
                        report_mismatch($sformatf("polygon_valid got %b, want %b",
                                                  m_polygon_valid, oldest.valid));
                end
            end
            if (s_valid && s_ready) begin
                if (s_opcode == pic_pkg::OP_LOAD) begin
                    if (s_restart)
                        vert_count = 0;
                    if (vert_count < MAX_VERTICES) begin
                        vert_x[vert_count] = s_x_coord;
                        vert_y[vert_count] = s_y_coord;
                        vert_count++;
                    end
                end else begin
                    answer_q.insert(answer_q.size(), predict_answer(s_x_coord, s_y_coord));
                end
            end
        end
        pending = answer_q.size();
    end

endmodule

### sim/point_in_convex_polygon_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_convex_polygon_tb: top level of the polygon point test bench
// Drives load and query requests (directed corners first, then random convex
// lenses, noise and degenerate shapes, then one full store) with bursty
// requests and a stalling receiver; the checker beside the block judges.
// ----------------------------------------------------------------------------
module point_in_convex_polygon_tb;

    localparam int     MAX_VERTS    = 1024;
    localparam int     HALF_PERIOD  = 10;
    localparam int     RESET_CYCLES = 9;
    localparam int     RANDOM_ITEMS = 450;
    // drain wait, longer than the slowest query
    localparam int     DRAIN_CYCLES = 120;
    localparam longint TIME_LIMIT   = 20_000_000;
    localparam longint COORD_MIN    = -1073741824;
    localparam longint COORD_MAX    = 1073741823;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_valid   = 1'b0;
    logic                               s_opcode  = pic_pkg::OP_LOAD;
    logic signed [pic_pkg::COORD_W-1:0] s_x_coord = '0;
    logic signed [pic_pkg::COORD_W-1:0] s_y_coord = '0;
    logic                               s_restart = 1'b0;
    logic                               m_ready   = 1'b0;
    wire                                s_ready;
    wire                                m_valid;
    wire                                m_inside_res;
    wire                                m_polygon_valid;

    int mismatches;
    int pending;

    // Polygon as last loaded; used to load the store and to aim query points
    pic_pkg::point_t shape [$];
    int     burst_left    = 0;
    bit     steady_sender = 1'b0;
    int     requests_sent = 0;
    int     stall_left    = 0;
    int     rx_cycle      = 0;

    always #HALF_PERIOD aclk = ~aclk;

    point_in_convex_polygon #(
        .MAX_VERTICES    (MAX_VERTS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_x_coord       (s_x_coord),
        .s_y_coord       (s_y_coord),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inside_res    (m_inside_res),
        .m_polygon_valid (m_polygon_valid)
    );

    point_in_convex_polygon_check #(
        .MAX_VERTICES    (MAX_VERTS)
    ) i_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_x_coord       (s_x_coord),
        .s_y_coord       (s_y_coord),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inside_res    (m_inside_res),
        .m_polygon_valid (m_polygon_valid),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    // Receiver: open stretches alternate with random stall runs;
    // change m_ready at the falling edge only
    always @(negedge aclk) begin
        rx_cycle++;
        if ((rx_cycle / 300) % 3 == 0) begin
            m_ready = 1'b1;
        end else if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready = 1'b0;
            stall_left = $urandom_range(0, 11);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Saturate to the 31-bit coordinate range
    function automatic logic signed [pic_pkg::COORD_W-1:0] to_coord(input longint v);
        if (v < COORD_MIN)
            v = COORD_MIN;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[pic_pkg::COORD_W-1:0];
    endfunction

    function automatic pic_pkg::point_t mk_pt(input longint x, input longint y);
        pic_pkg::point_t p;
        p.x = to_coord(x);
        p.y = to_coord(y);
        return p;
    endfunction

    function automatic pic_pkg::point_t rand_pt();
        pic_pkg::point_t p;
        p.x = pic_pkg::COORD_W'($urandom);
        p.y = pic_pkg::COORD_W'($urandom);
        return p;
    endfunction

    // Present one request and hold it until accepted. Open a new burst with
    // a random gap, or none at all while the sender runs steady.
    task automatic send_request(input logic op, input pic_pkg::point_t p, input logic rs);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = steady_sender ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid   = 1'b1;
        s_opcode  = op;
        s_x_coord = p.x;
        s_y_coord = p.y;
        s_restart = rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        requests_sent++;
        @(negedge aclk);
    endtask

    // Query with a random restart bit; the block must ignore it on a query
    task automatic send_query(input pic_pkg::point_t p);
        send_request(pic_pkg::OP_QUERY, p, 1'($urandom_range(0, 1)));
    endtask

    // Build a strictly convex lens: a lower parabola left to right, then an
    // upper one back. Random scale, position, start vertex and winding.
    task automatic build_lens(input int ulim, input int step_max);
        longint s, t, cx, cy, lo, hi, u, top;
        pic_pkg::point_t p;
        pic_pkg::point_t pts [$];
        int     n, rot, k;
        bit     cw;
        shape.delete();
        s   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8)
                                          : $urandom_range(1, (1 << 29) / ulim);
        t   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8)
                                          : $urandom_range(1, (1 << 29) / (2 * ulim * ulim));
        lo  = COORD_MIN + s * ulim;
        hi  = COORD_MAX - s * ulim;
        cx  = lo + $urandom_range(0, hi - lo);
        top = 2 * t * ulim * ulim;
        cy  = COORD_MIN + $urandom_range(0, COORD_MAX - top - COORD_MIN);
        u   = -ulim;
        while (u < ulim) begin
            pts.insert(pts.size(), mk_pt(cx + s * u, cy + t * u * u));
            u = u + $urandom_range(1, step_max);
        end
        pts.insert(pts.size(), mk_pt(cx + s * ulim, cy + t * ulim * ulim));
        u = ulim - $urandom_range(1, step_max);
        while (u > -ulim) begin
            pts.insert(pts.size(), mk_pt(cx + s * u, cy + top - t * u * u));
            u = u - $urandom_range(1, step_max);
        end
        n   = pts.size();
        rot = $urandom_range(0, n - 1);
        cw  = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            k = cw ? (rot - i + n) % n : (rot + i) % n;
            shape.insert(shape.size(), pts[k]);
        end
    endtask

    task automatic load_shape();
        foreach (shape[i])
            send_request(pic_pkg::OP_LOAD, shape[i], i == 0);
    endtask

    // Aim a query at the current shape: a vertex, a point next to one, an
    // edge midpoint, a point in the bounding box, the centroid, a corner of
    // the coordinate range or anywhere at all
    task automatic probe_shape();
        pic_pkg::point_t a, b, p;
        longint minx, maxx, miny, maxy, sx, sy;
        int     n, i, off_x, off_y;
        n = shape.size();
        if (n == 0) begin
            send_query(rand_pt());
            return;
        end
        i = $urandom_range(0, n - 1);
        a = shape[i];
        b = shape[(i + 1) % n];
        minx = COORD_MAX; maxx = COORD_MIN; miny = COORD_MAX; maxy = COORD_MIN;
        sx = 0; sy = 0;
        foreach (shape[j]) begin
            if (shape[j].x < minx) minx = shape[j].x;
            if (shape[j].x > maxx) maxx = shape[j].x;
            if (shape[j].y < miny) miny = shape[j].y;
            if (shape[j].y > maxy) maxy = shape[j].y;
            sx += shape[j].x;
            sy += shape[j].y;
        end
        case ($urandom_range(0, 7))
            0: p = a;
            1: begin
                off_x = $urandom_range(0, 2);
                off_y = $urandom_range(0, 2);
                p = mk_pt(longint'(a.x) + off_x - 1, longint'(a.y) + off_y - 1);
            end
            2: p = mk_pt((longint'(a.x) + b.x) / 2, (longint'(a.y) + b.y) / 2);
            3, 4: p = mk_pt(minx + $urandom_range(0, maxx - minx),
                            miny + $urandom_range(0, maxy - miny));
            5: p = mk_pt(sx / n, sy / n);
            6: p = mk_pt($urandom_range(0, 1) ? COORD_MIN : COORD_MAX,
                         $urandom_range(0, 1) ? COORD_MIN : COORD_MAX);
            default: p = rand_pt();
        endcase
        send_query(p);
    endtask

    // Stimulus and verdict
    initial begin
        int base, pick, k;
        pic_pkg::point_t p;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Empty store, then one and two vertices: all answer invalid
        send_query(mk_pt(0, 0));
        send_request(pic_pkg::OP_LOAD, mk_pt(COORD_MIN, COORD_MIN), 1'b1);
        send_query(mk_pt(0, 0));
        send_request(pic_pkg::OP_LOAD, mk_pt(COORD_MAX, COORD_MIN), 1'b0);
        send_query(mk_pt(COORD_MAX, COORD_MAX));
        // Triangle at the coordinate extremes; the origin sits on its diagonal
        send_request(pic_pkg::OP_LOAD, mk_pt(COORD_MAX, COORD_MAX), 1'b0);
        send_query(mk_pt(0, 0));
        send_query(mk_pt(COORD_MIN, COORD_MAX));
        // Full-range square: corners, center and edge points
        send_request(pic_pkg::OP_LOAD, mk_pt(COORD_MIN, COORD_MAX), 1'b0);
        send_query(mk_pt(COORD_MIN, COORD_MIN));
        send_query(mk_pt(COORD_MAX, COORD_MAX));
        send_query(mk_pt(0, 0));
        send_query(mk_pt(COORD_MIN, 0));
        send_query(mk_pt(COORD_MAX, -1));
        send_query(mk_pt(0, COORD_MAX));
        // Small clockwise square: inside, outside, on an edge
        send_request(pic_pkg::OP_LOAD, mk_pt(0, 0), 1'b1);
        send_request(pic_pkg::OP_LOAD, mk_pt(0, 10), 1'b0);
        send_request(pic_pkg::OP_LOAD, mk_pt(10, 10), 1'b0);
        send_request(pic_pkg::OP_LOAD, mk_pt(10, 0), 1'b0);
        send_query(mk_pt(5, 5));
        send_query(mk_pt(11, 5));
        send_query(mk_pt(10, 5));

        // Random part: mostly convex lenses with aimed queries
        base = requests_sent;
        while (requests_sent - base < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            steady_sender = ($urandom_range(0, 3) == 0);
            if (pick < 70) begin
                build_lens($urandom_range(1, 8), $urandom_range(1, 3));
                load_shape();
                repeat ($urandom_range(2, 8)) probe_shape();
            end else if (pick < 82) begin
                // noise: random vertices, appended or on a fresh store
                k = $urandom_range(0, 1);
                if (k) shape.delete();
                repeat ($urandom_range(1, 6)) begin
                    p = rand_pt();
                    send_request(pic_pkg::OP_LOAD, p, k == 1);
                    shape.insert(shape.size(), p);
                    k = 0;
                end
                repeat ($urandom_range(2, 5)) probe_shape();
            end else if (pick < 92) begin
                // fewer than three vertices
                shape.delete();
                k = $urandom_range(1, 2);
                for (int j = 0; j < k; j++) begin
                    p = rand_pt();
                    send_request(pic_pkg::OP_LOAD, p, j == 0);
                    shape.insert(shape.size(), p);
                end
                repeat ($urandom_range(1, 3)) probe_shape();
            end else if (pick < 97) begin
                // degenerate: collinear vertices
                shape.delete();
                k = $urandom_range(3, 6);
                for (int j = 0; j < k; j++)
                    shape.insert(shape.size(), mk_pt(-1000 + 300 * j, 500 - 200 * j));
                load_shape();
                repeat ($urandom_range(2, 5)) probe_shape();
            end else begin
                build_lens($urandom_range(16, 48), $urandom_range(1, 3));
                load_shape();
                repeat ($urandom_range(4, 10)) probe_shape();
            end
        end

        // Full store: 1024 vertices, loads past capacity dropped, then a
        // restart on a full store must still take its vertex
        steady_sender = 1'b0;
        build_lens(256, 1);
        load_shape();
        repeat (4) send_request(pic_pkg::OP_LOAD, rand_pt(), 1'b0);
        repeat (12) probe_shape();
        p = rand_pt();
        send_request(pic_pkg::OP_LOAD, p, 1'b1);
        send_query(rand_pt());
        send_request(pic_pkg::OP_LOAD, rand_pt(), 1'b0);
        send_request(pic_pkg::OP_LOAD, rand_pt(), 1'b0);
        repeat (3) send_query(rand_pt());

        // Drain: hold valid low, wait for every answer, then watch for strays
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("point_in_convex_polygon_tb passed");
        else
            $display("point_in_convex_polygon_tb failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIME_LIMIT);
        $display("point_in_convex_polygon_tb failed");
        $finish;
    end

endmodule
